// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define TCW_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tcw_pkg.sv
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = ROWS * COLUMNS;
    localparam int CELL_AW  = $clog2(CELLS);

    // Field widths.
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int CELL_W   = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W = 1;

    // Tab stops.
    localparam int TAB_STOP = 8;
    localparam int TAB_W    = $clog2(TAB_STOP);

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    // Operations.
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

    // Reset attribute colors.
    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic clr_step;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic will_scroll;
        logic clr_last;
        logic out_free;
    } t_ctl_sts;

endpackage

// File: rtl/core/tcw_if.sv
interface tcw_in_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;

    modport source (output valid, operation, char_code, read_row, read_col, input ready);
    modport sink   (input valid, operation, char_code, read_row, read_col, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;

    modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
                    input ready);
    modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
                    output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/text_console_char_writer_top.sv
// Channel   Direction  Contents
// i_in      sink       operation, char_code, read_row, read_col
// o_out     source     cell_char, cell_attr, cursor_col, cursor_row, scrolled
// i_cfg     sink       index (0 foreground, 1 background), data (4-bit color)
//
// An item passes through the accept, an execute step on the cell buffer and
// a step that loads the result register.
// A put item that scrolls also blanks the new bottom row, one cell per cycle
// through the single write port of the buffer.
// After reset the buffer is cleared at one cell per cycle, all ROWS * COLUMNS
// cells, while input transactions are held off; configuration writes go through.
// A stalled result waits in the output register; the next input transaction is
// taken while it waits, and its own result waits until the register frees.
module text_console_char_writer_top import tcw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcw_in_if.sink        i_in,
    tcw_out_if.source     o_out,
    tcw_cfg_if.sink       i_cfg
);

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;

    // Configuration writes land in a register at once, so the port never stalls.
    assign i_cfg.ready = 1'b1;

    // The controller sequences each transaction: clearing sweep, execute,
    // optional row blanking for a scroll, and the hand-off to the output register.
    tcw_controller u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    // The datapath holds the cell buffer (a ring of rows, so a scroll only
    // moves the base row and blanks one row), the cursor and the colors.
    tcw_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctl_cmd),
        .o_sts        (ctl_sts),
        .i_operation  (i_in.operation),
        .i_char_code  (i_in.char_code),
        .i_read_row   (i_in.read_row),
        .i_read_col   (i_in.read_col),
        .i_cfg_write  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_cell_char  (o_out.cell_char),
        .o_cell_attr  (o_out.cell_attr),
        .o_cursor_col (o_out.cursor_col),
        .o_cursor_row (o_out.cursor_row),
        .o_scrolled   (o_out.scrolled)
    );

endmodule

// File: rtl/core/tcw_controller.sv
module tcw_controller import tcw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.will_scroll ? S_SCROLL : S_DONE;
            end
            S_SCROLL: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/core/tcw_datapath.sv
module tcw_datapath import tcw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl_cmd             i_cmd,
    output t_ctl_sts             o_sts,
    input  logic                 i_operation,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [ROW_W-1:0]     i_read_row,
    input  logic [COL_W-1:0]     i_read_col,
    input  logic                 i_cfg_write,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CHAR_W-1:0]    o_cell_char,
    output logic [ATTR_W-1:0]    o_cell_attr,
    output logic [COL_W-1:0]     o_cursor_col,
    output logic [ROW_W-1:0]     o_cursor_row,
    output logic                 o_scrolled
);

    // Rows live in a ring: logical row r sits in physical row (r + base) mod ROWS.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return CELL_AW'(row) * CELL_AW'(COLUMNS) + CELL_AW'(col);
    endfunction

    logic [CELL_W-1:0]  r_mem [CELLS];
    logic [CELL_W-1:0]  r_rdata;

    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;

    logic               r_op;
    logic [CHAR_W-1:0]  r_char;
    logic [ROW_W-1:0]   r_rrow;
    logic [COL_W-1:0]   r_rcol;

    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_base;
    logic [CELL_AW-1:0] r_clr_addr;
    logic [CELL_AW-1:0] r_clr_left;
    logic               r_scrolled;
    logic               r_rd_ok;

    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic [ATTR_W-1:0]  r_out_attr;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic               r_out_scrolled;

    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic [COL_W:0]     adv_col;
    logic               do_adv;
    logic               do_nl;
    logic               scroll;
    logic               wr_cell;
    logic               wr_blank;
    logic               rd_ok;
    logic [ROW_W-1:0]   w_row;
    logic [COL_W-1:0]   w_col;
    logic               mem_we;
    logic [CELL_AW-1:0] mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [CELL_AW-1:0] mem_raddr;

    // Cursor update for a put item.
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        adv_col  = '0;
        do_adv   = 1'b0;
        do_nl    = 1'b0;
        scroll   = 1'b0;
        wr_cell  = 1'b0;
        wr_blank = 1'b0;
        w_row    = r_row;
        w_col    = r_col;
        if (r_op == OP_PUT) begin
            unique case (r_char)
                CH_LF: begin
                    do_nl = 1'b1;
                end
                CH_CR: begin
                    n_col = '0;
                end
                CH_TAB: begin
                    adv_col = {1'b0, r_col[COL_W-1:TAB_W], TAB_W'(0)} + (COL_W+1)'(TAB_STOP);
                    do_adv  = 1'b1;
                end
                CH_BS: begin
                    if (r_col != '0) begin
                        n_col = r_col - 1'b1;
                    end else if (r_row != '0) begin
                        n_row = r_row - 1'b1;
                        n_col = COL_W'(COLUMNS - 1);
                    end
                    wr_cell  = 1'b1;
                    wr_blank = 1'b1;
                    w_row    = n_row;
                    w_col    = n_col;
                end
                default: begin
                    wr_cell = 1'b1;
                    adv_col = {1'b0, r_col} + 1'b1;
                    do_adv  = 1'b1;
                end
            endcase
            if (do_adv) begin
                if (adv_col < (COL_W+1)'(COLUMNS)) begin
                    n_col = adv_col[COL_W-1:0];
                end else begin
                    do_nl = 1'b1;
                end
            end
            if (do_nl) begin
                n_col = '0;
                if (r_row == ROW_W'(ROWS - 1)) begin
                    scroll = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
        end
    end

    assign rd_ok = (r_op == OP_READ) &&
                   ({1'b0, r_rrow} < (ROW_W+1)'(ROWS)) &&
                   ({1'b0, r_rcol} < (COL_W+1)'(COLUMNS));

    // Single write port shared by cell updates and the clearing sweeps.
    assign mem_we    = i_cmd.clr_step || (i_cmd.exec && wr_cell);
    assign mem_waddr = i_cmd.clr_step ? r_clr_addr : cell_addr(phys_row(w_row, r_base), w_col);
    assign mem_wdata = (i_cmd.clr_step || wr_blank) ? '0 : {r_bg, r_fg, r_char};
    assign mem_re    = i_cmd.exec && rd_ok;
    assign mem_raddr = cell_addr(phys_row(r_rrow, r_base), r_rcol);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_FG:  r_fg <= i_cfg_data;
                CFG_BG:  r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_operation;
            r_char <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
        if (i_cmd.exec) begin
            r_scrolled <= scroll;
            r_rd_ok    <= rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_base     <= '0;
            r_clr_addr <= '0;
            r_clr_left <= CELL_AW'(CELLS - 1);
        end else if (i_cmd.exec) begin
            r_col <= n_col;
            r_row <= n_row;
            if (scroll) begin
                // The old top row becomes the new bottom row and is blanked.
                r_base     <= (r_base == ROW_W'(ROWS - 1)) ? '0 : r_base + 1'b1;
                r_clr_addr <= cell_addr(r_base, '0);
                r_clr_left <= CELL_AW'(COLUMNS - 1);
            end
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            r_clr_left <= r_clr_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_char     <= r_rd_ok ? r_rdata[CHAR_W-1:0] : '0;
            r_out_attr     <= r_rd_ok ? r_rdata[CELL_W-1:CHAR_W] : '0;
            r_out_col      <= r_col;
            r_out_row      <= r_row;
            r_out_scrolled <= r_scrolled;
        end
    end

    assign o_sts.will_scroll = scroll;
    assign o_sts.clr_last    = (r_clr_left == '0);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_scrolled   = r_out_scrolled;

endmodule

// File: rtl/core/tcw_checker.sv
`include "assert_macros.svh"

module tcw_checker import tcw_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [COL_W-1:0] i_out_col,
    input logic [ROW_W-1:0] i_out_row,
    input logic             i_out_scrolled
);

    logic row_ok;
    logic col_ok;
    logic scroll_ok;

    assign row_ok    = ({1'b0, i_out_row} < (ROW_W+1)'(ROWS));
    assign col_ok    = ({1'b0, i_out_col} < (COL_W+1)'(COLUMNS));
    assign scroll_ok = (i_out_col == '0) && (i_out_row == ROW_W'(ROWS - 1));

    `TCW_ASSERT(a_row_range, i_clk, i_rst_n, i_out_valid |-> row_ok, "cursor row off screen")
    `TCW_ASSERT(a_col_range, i_clk, i_rst_n, i_out_valid |-> col_ok, "cursor column off screen")
    `TCW_ASSERT(a_scroll_pos, i_clk, i_rst_n, (i_out_valid && i_out_scrolled) |-> scroll_ok, "scroll must leave cursor at start of last row")
    `TCW_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_col) && $stable(i_out_row)), "stalled result changed")
    `TCW_ASSERT_NR(a_clear_block, i_clk, !i_rst_n |=> !i_in_ready, "input taken during clearing sweep")

endmodule

bind text_console_char_writer_top tcw_checker u_tcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_col      (o_out.cursor_col),
    .i_out_row      (o_out.cursor_row),
    .i_out_scrolled (o_out.scrolled)
);

// File: tb/sv/text_console_char_writer_top_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the text console writer. Put and read requests are
// queued by the stimulus process, driven by a clocked driver with random gaps,
// and predicted at the moment the block accepts them. Responses are collected
// by a clocked monitor with random stalls and checked in order against the
// predictions.
module text_console_char_writer_top_test;
    import tcw_pkg::*;

    // One console request as it travels on the input channel.
    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_console_req;

    // One console response as it comes back on the output channel.
    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
    } t_console_resp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcw_in_if  req_ch ();
    tcw_out_if resp_ch ();
    tcw_cfg_if color_ch ();

    text_console_char_writer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (resp_ch),
        .i_cfg   (color_ch)
    );

    // 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Shadow of the console: the cell buffer, the cursor and the colors.
    logic [CELL_W-1:0]  screen_cells [CELLS];
    int                 pen_col;
    int                 pen_row;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;

    t_console_req  pending_requests[$];
    t_console_resp predicted_responses[$];

    int  n_accepted;
    int  n_mismatch;
    bit  req_busy;
    int  req_gap;
    int  req_quiet;
    int  resp_stall;
    int  resp_quiet;
    bit  hold_off;

    // Moves the cursor to the given column of the current row. A column at or
    // past the right edge wraps to column 0 of the next row, and wrapping off
    // the last row scrolls the buffer up by one row and blanks the bottom row.
    // Returns 1 when a scroll happened.
    function automatic bit advance_cursor(int col);
        if (col < COLUMNS) begin
            pen_col = col;
            return 1'b0;
        end
        pen_col = 0;
        if (pen_row + 1 < ROWS) begin
            pen_row++;
            return 1'b0;
        end
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_cells[i] = screen_cells[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_cells[i] = '0;
        return 1'b1;
    endfunction

    // Applies one accepted request to the shadow console and returns the
    // response that the block must give for it.
    function automatic t_console_resp console_step(t_console_req req);
        t_console_resp resp;
        logic [CELL_W-1:0] cell_word;
        resp = '0;
        if (req.op == OP_READ) begin
            // Reads outside the screen return an empty cell.
            if (req.read_row < ROWS && req.read_col < COLUMNS) begin
                cell_word = screen_cells[req.read_row * COLUMNS + req.read_col];
                resp.cell_char = cell_word[CHAR_W-1:0];
                resp.cell_attr = cell_word[CELL_W-1:CHAR_W];
            end
        end else begin
            case (req.char_code)
                CH_LF:  resp.scrolled = advance_cursor(COLUMNS);
                CH_CR:  pen_col = 0;
                CH_TAB: resp.scrolled = advance_cursor(pen_col + TAB_STOP - pen_col % TAB_STOP);
                CH_BS: begin
                    // Step back one cell, across the row boundary if needed; at the
                    // home position the cursor stays put. The landing cell is cleared.
                    if (pen_col > 0) begin
                        pen_col--;
                    end else if (pen_row > 0) begin
                        pen_row--;
                        pen_col = COLUMNS - 1;
                    end
                    screen_cells[pen_row * COLUMNS + pen_col] = '0;
                end
                default: begin
                    screen_cells[pen_row * COLUMNS + pen_col] = {bg_color, fg_color, req.char_code};
                    resp.scrolled = advance_cursor(pen_col + 1);
                end
            endcase
        end
        resp.cursor_col = pen_col[COL_W-1:0];
        resp.cursor_row = pen_row[ROW_W-1:0];
        return resp;
    endfunction

    function automatic void queue_put(logic [CHAR_W-1:0] ch);
        pending_requests.push_back('{op: OP_PUT, char_code: ch, read_row: '0, read_col: '0});
    endfunction

    function automatic void queue_read(int row, int col);
        pending_requests.push_back('{op: OP_READ, char_code: '0,
                                     read_row: row[ROW_W-1:0], read_col: col[COL_W-1:0]});
    endfunction

    // Writes one color register. The shadow copy changes only once the block
    // has taken the transaction.
    task automatic write_color(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
        @(negedge i_clk);
        color_ch.valid <= 1'b1;
        color_ch.index <= idx;
        color_ch.data  <= value;
        @(posedge i_clk);
        while (!color_ch.ready)
            @(posedge i_clk);
        if (idx == CFG_FG)
            fg_color = value;
        else
            bg_color = value;
        @(negedge i_clk);
        color_ch.valid <= 1'b0;
    endtask

    // Waits until every queued request has been taken and answered.
    task automatic drain();
        while (pending_requests.size() != 0 || req_busy || predicted_responses.size() != 0)
            @(posedge i_clk);
    endtask

    // Request driver. A new request goes out at the falling edge once the
    // previous one has been taken and its idle gap has run out. The valid line
    // gets exactly one assignment per edge, so a back-to-back request keeps it
    // high without a glitch.
    always @(negedge i_clk) begin
        logic next_valid;
        t_console_req req;
        next_valid = req_busy;
        if (!req_busy) begin
            if (req_gap > 0) begin
                req_gap--;
            end else if (i_rst_n && pending_requests.size() != 0) begin
                req = pending_requests.pop_front();
                req_ch.operation <= req.op;
                req_ch.char_code <= req.char_code;
                req_ch.read_row  <= req.read_row;
                req_ch.read_col  <= req.read_col;
                next_valid = 1'b1;
                req_busy   = 1'b1;
                // Mostly random gaps, with occasional stretches of none at all.
                if (req_quiet > 0) begin
                    req_quiet--;
                    req_gap = 0;
                end else begin
                    req_gap = $urandom_range(0, 16);
                    if ($urandom_range(0, 24) == 0)
                        req_quiet = $urandom_range(8, 40);
                end
            end
        end
        req_ch.valid <= next_valid;
    end

    // Prediction happens at the accepting edge, so the shadow state always
    // follows the block's own order of requests.
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            predicted_responses.push_back(console_step('{op: req_ch.operation,
                char_code: req_ch.char_code, read_row: req_ch.read_row,
                read_col: req_ch.read_col}));
            req_busy = 1'b0;
            n_accepted++;
        end
    end

    // Response side ready control. Each response is followed by a random
    // stall; the long hold-off overrides everything while it lasts.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            resp_ch.ready <= 1'b0;
        end else if (resp_stall > 0) begin
            resp_stall--;
            resp_ch.ready <= 1'b0;
        end else begin
            resp_ch.ready <= 1'b1;
        end
    end

    // Response checker: every transaction is compared with the oldest
    // prediction.
    always @(posedge i_clk) begin
        t_console_resp got;
        t_console_resp want;
        if (i_rst_n && resp_ch.valid && resp_ch.ready) begin
            got = '{cell_char: resp_ch.cell_char, cell_attr: resp_ch.cell_attr,
                    cursor_col: resp_ch.cursor_col, cursor_row: resp_ch.cursor_row,
                    scrolled: resp_ch.scrolled};
            if (predicted_responses.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("%0t: response with none outstanding: char %0h attr %0h col %0d row %0d scrolled %0b",
                             $realtime, got.cell_char, got.cell_attr, got.cursor_col,
                             got.cursor_row, got.scrolled);
            end else begin
                want = predicted_responses.pop_front();
                if (got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
                    got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
                    got.scrolled !== want.scrolled) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: mismatch: expected char %0h attr %0h col %0d row %0d scrolled %0b, got char %0h attr %0h col %0d row %0d scrolled %0b",
                                 $realtime, want.cell_char, want.cell_attr, want.cursor_col,
                                 want.cursor_row, want.scrolled, got.cell_char, got.cell_attr,
                                 got.cursor_col, got.cursor_row, got.scrolled);
                end
            end
            if (resp_quiet > 0) begin
                resp_quiet--;
                resp_stall = 0;
            end else begin
                resp_stall = $urandom_range(0, 16);
                if ($urandom_range(0, 24) == 0)
                    resp_quiet = $urandom_range(8, 40);
            end
        end
    end

    // Long receiver hold-off in the middle of the first random phase. The
    // driver keeps offering requests, so the result register and the pipeline
    // fill and the block has to stall its input.
    initial begin
        hold_off = 1'b0;
        wait (n_accepted >= 80);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300)
            @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Slowest correct run: about 600 requests, each with the longest send gap,
    // its work plus the row blanking for a scroll and the longest receive stall,
    // plus the clear after reset and the hold-off. That stays well inside the limit.
    initial begin
        #(400_000 * 20);
        $display("** text_console_char_writer_top: FAILED **");
        $finish;
    end

    initial begin
        int unsigned pick;
        int          n_items;
        int          row;
        int          col;
        logic [COLOR_W-1:0] fg_setting [4];
        logic [COLOR_W-1:0] bg_setting [4];

        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_PUT;
        req_ch.char_code = '0;
        req_ch.read_row  = '0;
        req_ch.read_col  = '0;
        resp_ch.ready    = 1'b0;
        color_ch.valid   = 1'b0;
        color_ch.index   = CFG_FG;
        color_ch.data    = '0;

        for (int i = 0; i < CELLS; i++)
            screen_cells[i] = '0;
        pen_col     = 0;
        pen_row     = 0;
        fg_color    = FG_RESET;
        bg_color    = BG_RESET;
        n_accepted  = 0;
        n_mismatch  = 0;
        req_busy    = 1'b0;
        req_gap     = 0;
        req_quiet   = 0;
        resp_stall  = 0;
        resp_quiet  = 0;

        repeat (12)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part with the reset colors. The buffer must read back empty
        // after reset, then each control code is exercised at the edges.
        queue_read(0, 0);
        queue_put(8'h00);                 // zero is printed like any other byte
        queue_put(8'hFF);
        queue_read(0, 0);
        queue_read(0, 1);
        queue_put(CH_TAB);                // column 2 to the next tab stop
        queue_put(8'h41);
        queue_put(CH_CR);
        queue_put(CH_BS);                 // at the home position: stays, clears the cell
        queue_read(0, 0);
        queue_put(CH_LF);
        queue_put(CH_BS);                 // from column 0 back to the end of the row above
        queue_put(8'h7E);                 // printed in the last column, wraps
        queue_read(0, COLUMNS - 1);
        queue_read(ROWS - 1, COLUMNS - 1);
        queue_read(ROWS, 0);              // rows and columns past the screen read empty
        queue_read(31, 127);
        queue_read(0, COLUMNS);
        queue_put(CH_TAB);
        queue_put(CH_BS);
        pending_requests.push_back('{op: OP_PUT, char_code: 8'h55, read_row: 5'd31,
                                     read_col: 7'd127});
        drain();

        // Random phases, each with its own colors, extremes included. The mix
        // is mostly printable text with enough newlines, tabs and wraps to run
        // the cursor off the bottom row and scroll many times.
        fg_setting = '{4'h0, 4'hF, 4'h0, 4'h0};
        bg_setting = '{4'h0, 4'hF, 4'hF, 4'h0};
        fg_setting[2] = COLOR_W'($urandom_range(0, 15));
        fg_setting[3] = 4'hF;
        bg_setting[3] = COLOR_W'($urandom_range(0, 15));
        for (int phase = 0; phase < 4; phase++) begin
            write_color(CFG_FG, fg_setting[phase]);
            write_color(CFG_BG, bg_setting[phase]);
            n_items = 135;
            for (int n = 0; n < n_items; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    // Reads lean on the bottom rows, where text piles up after
                    // scrolling, and now and then fall off the screen.
                    if ($urandom_range(0, 9) == 0)
                        row = $urandom_range(0, 31);
                    else if ($urandom_range(0, 1) == 0)
                        row = $urandom_range(ROWS - 5, ROWS - 1);
                    else
                        row = $urandom_range(0, ROWS - 1);
                    if ($urandom_range(0, 9) == 0)
                        col = $urandom_range(0, 127);
                    else
                        col = $urandom_range(0, COLUMNS - 1);
                    queue_read(row, col);
                end else begin
                    // Put requests carry random read coordinates, which must be
                    // ignored.
                    pending_requests.push_back('{op: OP_PUT, char_code: '0,
                        read_row: ROW_W'($urandom_range(0, 31)),
                        read_col: COL_W'($urandom_range(0, 127))});
                    if (pick < 34)
                        pending_requests[$].char_code = CH_LF;
                    else if (pick < 38)
                        pending_requests[$].char_code = CH_CR;
                    else if (pick < 44)
                        pending_requests[$].char_code = CH_TAB;
                    else if (pick < 50)
                        pending_requests[$].char_code = CH_BS;
                    else
                        pending_requests[$].char_code = CHAR_W'($urandom_range(0, 255));
                end
            end
            drain();
        end

        // A scroll keeps the block busy while the new bottom row is blanked.
        repeat (100)
            @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("** text_console_char_writer_top: PASSED **");
        end else begin
            $display("** text_console_char_writer_top: FAILED **");
        end
        $finish;
    end

endmodule
